FILE: design/hi4d_pkg.sv
// Shared constants for the 4-D Hilbert index encoder.
package hi4d_pkg;

    localparam int NDIM      = 4;
    localparam int COORD_W   = 17;
    localparam int FRAC_W    = 16;
    localparam int ORDER_W   = 5;
    localparam int IDX_W     = 64;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 64;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd16;
    localparam logic [FRAC_W-1:0]  HALF_Q16    = 16'h8000;

endpackage

FILE: design/hi4d_scale.sv
// Input stage: clamp each Q1.16 coordinate, scale to order bits, left-align.
module hi4d_scale #(
    parameter int W = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic [hi4d_pkg::ORDER_W-1:0]                  order_i,
    input  logic [hi4d_pkg::ORDER_W-1:0]                  shamt_i,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [hi4d_pkg::NDIM-1:0][hi4d_pkg::COORD_W-1:0] coord_i,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [hi4d_pkg::NDIM-1:0][W-1:0]              axis_o
);
    import hi4d_pkg::*;

    localparam int PW = COORD_W + W;

    logic                        valid_reg;
    logic [NDIM-1:0][W-1:0]      axis_reg;
    logic [NDIM-1:0][W-1:0]      axis_next;
    logic [W-1:0]                top;

    assign top = ~({W{1'b1}} << order_i);

    always_comb begin
        logic [PW-1:0]     c16;
        logic [PW-1:0]     prod;
        logic [W-1:0]      scaled;
        for (int i = 0; i < NDIM; i++) begin
            c16    = PW'(coord_i[i][FRAC_W-1:0]);
            prod   = (c16 << order_i) - c16 + PW'(HALF_Q16);
            if (coord_i[i] == '0) begin
                scaled = '0;
            end else if (coord_i[i][COORD_W-1]) begin
                scaled = top;
            end else begin
                scaled = prod[FRAC_W +: W];
            end
            // for a valid order, the msb of the axis lands on bit W-1
            axis_next[i] = scaled << shamt_i;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign axis_o    = axis_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            axis_reg <= axis_next;
        end
    end

endmodule

FILE: design/hi4d_cell.sv
// One bit level of the inverse-undo pass over the four aligned axes.
module hi4d_cell #(
    parameter int W   = 16,
    parameter int POS = 15
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [W-1:0]                      vmask_i,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [hi4d_pkg::NDIM-1:0][W-1:0]  axis_i,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [hi4d_pkg::NDIM-1:0][W-1:0]  axis_o
);
    import hi4d_pkg::*;

    localparam logic [W-1:0] LOW_BITS = W'((1 << POS) - 1);

    logic                        valid_reg;
    logic [NDIM-1:0][W-1:0]      axis_reg;
    logic [NDIM-1:0][W-1:0]      axis_next;
    logic [W-1:0]                low;

    // padding bits below the active order stay zero
    assign low = LOW_BITS & vmask_i;

    always_comb begin
        logic [W-1:0] t;
        t         = '0;
        axis_next = axis_i;
        for (int i = 0; i < NDIM; i++) begin
            if (axis_next[i][POS]) begin
                axis_next[0] = axis_next[0] ^ low;
            end else begin
                t            = (axis_next[0] ^ axis_next[i]) & low;
                axis_next[0] = axis_next[0] ^ t;
                axis_next[i] = axis_next[i] ^ t;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign axis_o    = axis_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            axis_reg <= axis_next;
        end
    end

endmodule

FILE: design/hi4d_out.sv
// Output stage: Gray encode, interleave bits msb first, drop padding, zero on bad order, output register.
module hi4d_out #(
    parameter int W = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [W-1:0]                      vmask_i,
    input  logic [hi4d_pkg::ORDER_W-1:0]      shamt_i,
    input  logic                              bad_i,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [hi4d_pkg::NDIM-1:0][W-1:0]  axis_i,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [hi4d_pkg::IDX_W-1:0]        index_o,
    output logic                              bad_o
);
    import hi4d_pkg::*;

    localparam int FW = NDIM * W;

    logic                        valid_reg;
    logic [IDX_W-1:0]            index_reg;
    logic [IDX_W-1:0]            index_next;
    logic                        bad_reg;
    logic [NDIM-1:0][W-1:0]      gray;
    logic [W-1:0]                tfix;
    logic [FW-1:0]               full;

    always_comb begin
        gray[0] = axis_i[0];
        for (int i = 1; i < NDIM; i++) begin
            gray[i] = gray[i-1] ^ axis_i[i];
        end
    end

    // tfix[j]: parity of gray[NDIM-1] bits above j, zero below the active order
    always_comb begin
        logic par;
        for (int j = 0; j < W; j++) begin
            par = 1'b0;
            for (int p = j + 1; p < W; p++) begin
                par = par ^ gray[NDIM-1][p];
            end
            tfix[j] = par & vmask_i[j];
        end
    end

    always_comb begin
        for (int p = 0; p < W; p++) begin
            for (int i = 0; i < NDIM; i++) begin
                full[NDIM*p + (NDIM-1-i)] = gray[i][p] ^ tfix[p];
            end
        end
    end

    always_comb begin
        logic [FW-1:0] shifted;
        shifted    = full >> ({2'b00, shamt_i} << 2);
        index_next = bad_i ? '0 : IDX_W'(shifted);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign index_o   = index_reg;
    assign bad_o     = bad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            index_reg <= index_next;
            bad_reg   <= bad_i;
        end
    end

endmodule

FILE: design/hilbert_index_4d_encode.sv
// Top level: 4-D Hilbert curve index encoder, one point per beat.
//
// Input beats on s_t*: four unsigned Q1.16 coordinates (65536 is 1.0, larger
// clamps to 1.0). Result beats on m_t*: the Hilbert index in m_tdata, with
// 4*order significant bits, and a bad-order flag in m_tuser. An order outside
// 1..MAX_ORDER gives index 0 with the flag set.
// The user must write the order register through cfg_wr_en/cfg_wr_data only
// while no beat is in flight; the block does not enforce it. It resets to 16.
// Pipeline: a scale stage, MAX_ORDER-1 bit-level cells (one per level of the
// undo pass, top level first), and an output stage, each registered; one beat
// per cycle sustained while m_tready stays high.
// Each stage holds its own valid bit and takes a new beat when it is empty or
// its successor takes its beat, so bubbles close up behind a stalled output
// and s_tready drops only once every stage is full.
// Reset (aresetn low, synchronous) empties all stages and sets order to 16.
module hilbert_index_4d_encode #(
    parameter int MAX_ORDER = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [hi4d_pkg::ORDER_W-1:0]     cfg_wr_data,   // order
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // coord_0 [16:0], coord_1 [33:17], coord_2 [50:34], coord_3 [67:51], zero [71:68]
    input  logic [hi4d_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // hilbert_index [63:0]
    output logic [hi4d_pkg::M_TDATA_W-1:0]   m_tdata,
    // bad_order [0]
    output logic                             m_tuser
);
    import hi4d_pkg::*;

    localparam int W = MAX_ORDER;

    logic [ORDER_W-1:0]          order_reg;
    logic [ORDER_W-1:0]          shamt;
    logic [W-1:0]                vmask;
    logic                        bad;

    logic [NDIM-1:0][COORD_W-1:0] coord;

    logic [NDIM-1:0][W-1:0]      axis_s  [MAX_ORDER];
    logic                        valid_s [MAX_ORDER];
    logic                        ready_s [MAX_ORDER];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= ORDER_RESET;
        end else if (cfg_wr_en) begin
            order_reg <= cfg_wr_data;
        end
    end

    assign bad   = (order_reg == '0) || (order_reg > ORDER_W'(MAX_ORDER));
    assign shamt = ORDER_W'(MAX_ORDER) - order_reg;
    assign vmask = {W{1'b1}} << shamt;

    always_comb begin
        for (int i = 0; i < NDIM; i++) begin
            coord[i] = s_tdata[COORD_W*i +: COORD_W];
        end
    end

    hi4d_scale #(.W(W)) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .order_i   (order_reg),
        .shamt_i   (shamt),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .coord_i   (coord),
        .out_valid (valid_s[0]),
        .out_ready (ready_s[0]),
        .axis_o    (axis_s[0])
    );

    for (genvar j = 1; j < MAX_ORDER; j++) begin : g_chain
        hi4d_cell #(.W(W), .POS(MAX_ORDER - j)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .vmask_i   (vmask),
            .in_valid  (valid_s[j-1]),
            .in_ready  (ready_s[j-1]),
            .axis_i    (axis_s[j-1]),
            .out_valid (valid_s[j]),
            .out_ready (ready_s[j]),
            .axis_o    (axis_s[j])
        );
    end

    hi4d_out #(.W(W)) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .vmask_i   (vmask),
        .shamt_i   (shamt),
        .bad_i     (bad),
        .in_valid  (valid_s[MAX_ORDER-1]),
        .in_ready  (ready_s[MAX_ORDER-1]),
        .axis_i    (axis_s[MAX_ORDER-1]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .index_o   (m_tdata),
        .bad_o     (m_tuser)
    );

endmodule
